@@ design/esd_pkg.sv @@
// Package for the escape sequence decoder.
// Holds the mode and status codes, character constants and the decode result struct.
// No dependencies.
`timescale 1ns / 1ps

package esd_pkg;

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_ESCAPE  = 3'd1,
		MODE_HEX1    = 3'd2,
		MODE_HEX2    = 3'd3,
		MODE_DISCARD = 3'd4
	} mode_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_BADHEX = 2'd1;
	localparam status_t ST_BADESC = 2'd2;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_X         = 8'h78;

	localparam int SHOWN_BITS = 16;

	typedef struct packed {
		logic       emit;
		logic       last;
		status_t    status;
		logic [7:0] data;
		mode_t      next_mode;
		logic       load_nib;
		logic [3:0] nib;
	} dec_t;

endpackage

@@ design/esd_decode.sv @@
// Combinational decode of one character against the current decoder mode.
// Depends on esd_pkg for the mode codes, status codes and the dec_t struct.
`timescale 1ns / 1ps

module esd_decode
	import esd_pkg::*;
(
	input  logic [7:0] in_char,
	input  mode_t      mode,
	input  logic [3:0] high_nibble,
	output dec_t       dec
);

	logic       hex_ok;
	logic [3:0] hex_val;
	logic       esc_ok;
	logic [7:0] esc_val;
	mode_t      err_mode;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (in_char >= 8'h30 && in_char <= 8'h39) begin
			hex_val = 4'(in_char - 8'h30);
		end else if (in_char >= 8'h61 && in_char <= 8'h66) begin
			hex_val = 4'(in_char - 8'h57);
		end else if (in_char >= 8'h41 && in_char <= 8'h46) begin
			hex_val = 4'(in_char - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		esc_ok  = 1'b1;
		case (in_char)
			8'h5C:   esc_val = 8'h5C;
			8'h6E:   esc_val = 8'h0A;
			8'h72:   esc_val = 8'h0D;
			8'h74:   esc_val = 8'h09;
			8'h61:   esc_val = 8'h07;
			8'h62:   esc_val = 8'h08;
			8'h66:   esc_val = 8'h0C;
			8'h76:   esc_val = 8'h0B;
			default: begin
				esc_ok  = 1'b0;
				esc_val = 8'h00;
			end
		endcase
	end

	// An error on the terminating NUL ends the string outright, so no discarding follows.
	assign err_mode = (in_char == CH_NUL) ? MODE_NORMAL : MODE_DISCARD;

	always_comb begin
		dec           = '0;
		dec.next_mode = MODE_NORMAL;
		dec.status    = ST_OK;
		case (mode)
			MODE_ESCAPE: begin
				if (in_char == CH_X) begin
					dec.next_mode = MODE_HEX1;
				end else if (esc_ok) begin
					dec.emit = 1'b1;
					dec.data = esc_val;
				end else begin
					dec.emit      = 1'b1;
					dec.last      = 1'b1;
					dec.status    = ST_BADESC;
					dec.next_mode = err_mode;
				end
			end
			MODE_HEX1: begin
				if (hex_ok) begin
					dec.load_nib  = 1'b1;
					dec.nib       = hex_val;
					dec.next_mode = MODE_HEX2;
				end else begin
					dec.emit      = 1'b1;
					dec.last      = 1'b1;
					dec.status    = ST_BADHEX;
					dec.next_mode = err_mode;
				end
			end
			MODE_HEX2: begin
				if (hex_ok) begin
					dec.emit = 1'b1;
					dec.data = {high_nibble, hex_val};
				end else begin
					dec.emit      = 1'b1;
					dec.last      = 1'b1;
					dec.status    = ST_BADHEX;
					dec.next_mode = err_mode;
				end
			end
			MODE_DISCARD: begin
				dec.next_mode = (in_char == CH_NUL) ? MODE_NORMAL : MODE_DISCARD;
			end
			default: begin
				if (in_char == CH_NUL) begin
					dec.emit = 1'b1;
					dec.last = 1'b1;
				end else if (in_char == CH_BACKSLASH) begin
					dec.next_mode = MODE_ESCAPE;
				end else begin
					dec.emit = 1'b1;
					dec.data = in_char;
				end
			end
		endcase
	end

endmodule

@@ design/escape_sequence_decoder_unit.sv @@
// Top level of the escape sequence decoder: input register, mode and count state, result register.
// Depends on esd_pkg and esd_decode.
`timescale 1ns / 1ps

// Decodes a backslash-escaped, NUL-terminated string, one character per transfer, into bytes.
// Each input character is held in the input register, where it is decoded against the mode
// register, and the result moves into the output register; a new character can be taken
// every cycle, so the sustained rate is one character per clock while the output side keeps
// up. A data result carries the byte and the running count with tlast low; an end result has
// tlast high, tuser giving the status (ok, bad hex escape, unsupported escape) and the count
// of bytes decoded before the end. Characters after an error are dropped up to the next NUL.
// The count saturates at the counter width and is shown capped at 65535.
module escape_sequence_decoder_unit
	import esd_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] data_byte, [23:8] byte_count
	output logic        m_tlast,   // end_flag
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam logic [COUNT_BITS-1:0] CountMax = '1;

	logic                  valid_s1;
	logic [7:0]            char_s1;
	mode_t                 mode_q;
	logic [3:0]            nib_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [32:0]           shown_ext;
	logic [SHOWN_BITS-1:0] shown;
	dec_t                  dec;
	logic                  adv;

	esd_decode u_decode (
		.in_char     (char_s1),
		.mode        (mode_q),
		.high_nibble (nib_q),
		.dec         (dec)
	);

	assign adv      = valid_s1 && (!m_tvalid || m_tready || !dec.emit);
	assign s_tready = !valid_s1 || adv;

	assign cnt_inc   = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;
	assign shown_ext = dec.last ? 33'(cnt_q) : 33'(cnt_inc);
	assign shown     = (shown_ext > 33'h0FFFF) ? '1 : shown_ext[SHOWN_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			nib_q  <= 4'd0;
			cnt_q  <= '0;
		end else if (adv) begin
			mode_q <= dec.next_mode;
			if (dec.load_nib) begin
				nib_q <= dec.nib;
			end
			if (dec.emit) begin
				cnt_q <= dec.last ? '0 : cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv && dec.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && dec.emit) begin
			m_tdata <= {shown, dec.data};
			m_tlast <= dec.last;
			m_tuser <= dec.status;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
		else $error("End result carries a nonzero data byte.");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == ST_OK)
		else $error("Data result carries an error status.");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && dec.emit && dec.last |=> cnt_q == '0 && mode_q != MODE_ESCAPE)
		else $error("Count not cleared after an end result.");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && mode_q == MODE_DISCARD |-> !dec.emit)
		else $error("Result produced while discarding.");

endmodule
